// ----- rtl/core/assert_macros.svh -----
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define CHWG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CHWG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/chwg_pkg.sv -----
`default_nettype none
package chwg_pkg;

   localparam int DEF_MAX_DEGREE = 16;
   localparam int N_W = 8;
   localparam int REQ_W = 96;
   localparam int RSP_W = 320;
   localparam int DRE_DW_LSB = 256;
   localparam int DIM_DW_LSB = 288;

   localparam logic signed [31:0] ONE30 = 32'sh4000_0000;

   typedef struct packed {
      logic zero;
      logic hw;
      logic wd;
      logic signed [31:0] w;
      logic signed [N_W-1:0] n;
      logic negx;
      logic negy;
      logic [4:0] k;
   } side_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [31:0] r;
      logic signed [31:0] zr;
      logic signed [31:0] zi;
   } car_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [32:0] nq;
   } div_type;

   function automatic div_type div_step(div_type cur, logic [31:0] d);
      logic [32:0] r2;
      div_type nx;
      r2 = {cur.rem, cur.nq[32]};
      if (r2 >= {1'b0, d}) begin
         nx.rem = 32'(r2 - {1'b0, d});
         nx.nq = {cur.nq[31:0], 1'b1};
      end else begin
         nx.rem = r2[31:0];
         nx.nq = {cur.nq[31:0], 1'b0};
      end
      return nx;
   endfunction

   function automatic logic [4:0] lz_shift(logic [31:0] m);
      logic [4:0] k;
      k = 5'd0;
      for (int i = 0; i < 30; i++) begin
         if (m[i]) k = 5'(30 - i);
      end
      if (m[31:30] != 2'b00) k = 5'd0;
      return k;
   endfunction

   function automatic logic signed [63:0] rnd30(logic signed [63:0] v);
      logic [63:0] mg;
      logic [63:0] r;
      mg = v[63] ? (~v + 64'd1) : v;
      r = (mg + 64'h2000_0000) >> 30;
      return v[63] ? $signed(64'd0 - r) : $signed(r);
   endfunction

   function automatic logic signed [31:0] clamp1(logic signed [63:0] v);
      logic signed [31:0] c;
      if (v > 64'(ONE30)) c = ONE30;
      else if (v < -64'(ONE30)) c = -ONE30;
      else c = v[31:0];
      return c;
   endfunction

   function automatic logic [31:0] sat32(logic [63:0] p, logic neg);
      logic [63:0] m;
      logic [31:0] o;
      m = (p + 64'h2000_0000) >> 30;
      if (neg) o = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
      else o = (m > 64'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
      return o;
   endfunction

   function automatic logic [47:0] sat48(logic [63:0] plo, logic [47:0] phi, logic neg);
      logic [63:0] m;
      logic ovf;
      logic [47:0] o;
      ovf = phi >= 48'h0100_0000_0000;
      m = (64'(phi) << 16) + ((plo + 64'h8000) >> 16);
      if (neg) begin
         o = (ovf || m > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : 48'(64'd0 - m);
      end else begin
         o = (ovf || m > 64'h7fff_ffff_ffff) ? 48'h7fff_ffff_ffff : m[47:0];
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/cylindrical_harmonic_with_gradient.sv -----
`default_nettype none
// Streams 2-D vectors in and returns w*u^n (u the unit vector as a complex number) with the
// partials by x, y and w. One item is taken every cycle unless the pipeline holds. The path
// runs through the bit-serial square root (32 stages), the two normalizing dividers (33
// stages), one complex multiply stage per degree step and the four gradient dividers (33
// stages). When the result is not taken the whole pipeline holds. The degree register must
// only be written while nothing is in flight.
module cylindrical_harmonic_with_gradient
   import chwg_pkg::*;
#(
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wen,
   input  wire logic [5:0]       csr_wdata,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // x_coord, y_coord, weight_in
   input  wire logic [1:0]       req_tuser,  // has_weight, want_derivs
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // harm_re, imag_part, dre_dx, dre_dy, dim_dx,
                                             // dim_dy, dre_dw, dim_dw
   output logic [0:0]            rsp_tuser   // zero_length
);

   localparam int NSQ = 32;
   localparam int NDV = 33;
   localparam int SQ0 = 5;
   localparam int CD0 = SQ0 + NSQ;
   localparam int CL = CD0 + NDV;
   localparam int C_T = MAX_DEGREE + 1;
   localparam int C_H = MAX_DEGREE + 2;
   localparam int C_NM = MAX_DEGREE + 3;
   localparam int C_PD = MAX_DEGREE + 4;
   localparam int C_G = C_PD + NDV;
   localparam int C_M = C_G + 1;
   localparam int NC = C_M + 1;
   localparam int NS = CL + NC + 1;

   logic adv;
   logic signed [5:0] degree_ff;
   logic v_ff [NS];
   logic v_in [NS];
   side_type side_ff [NS];
   side_type side_in [NS];

   logic [31:0] ax0_ff, ay0_ff, ax0_in, ay0_in;
   logic [31:0] ax1_ff, ay1_ff;
   logic [31:0] a2_ff, b2_ff, a2_in, b2_in;
   logic [63:0] aa3_ff, bb3_ff, aa3_in, bb3_in;
   logic [31:0] a3_ff, b3_ff;
   logic [63:0] ss4_ff, ss4_in;
   logic [31:0] a4_ff, b4_ff;
   logic [63:0] sq_s_ff [NSQ];
   logic [63:0] sq_s_in [NSQ];
   logic [63:0] sq_r_ff [NSQ];
   logic [63:0] sq_r_in [NSQ];
   logic [31:0] sq_a_ff [NSQ];
   logic [31:0] sq_a_in [NSQ];
   logic [31:0] sq_b_ff [NSQ];
   logic [31:0] sq_b_in [NSQ];
   div_type cdx_ff [NDV];
   div_type cdx_in [NDV];
   div_type cdy_ff [NDV];
   div_type cdy_in [NDV];
   logic [31:0] cd_d_ff [NDV];
   logic [31:0] cd_d_in [NDV];
   car_type car_ff [NC];
   car_type car_in [NC];
   logic signed [63:0] tp_ff [4];
   logic signed [63:0] tp_in [4];
   logic signed [39:0] hh_ff [4];
   logic signed [39:0] hh_in [4];
   div_type nm_ff [4];
   div_type nm_in [4];
   logic nneg_ff [4];
   logic nneg_in [4];
   div_type pd_ff [NDV][4];
   div_type pd_in [NDV][4];
   logic pneg_ff [NDV][4];
   logic pneg_in [NDV][4];
   logic [47:0] g_ff [4];
   logic [47:0] g_in [4];
   logic gneg_ff [4];
   logic gneg_in [4];
   logic [63:0] plo_ff [4];
   logic [63:0] plo_in [4];
   logic [47:0] phi_ff [4];
   logic [47:0] phi_in [4];
   logic pn_ff [4];
   logic pn_in [4];
   logic [63:0] pre_ff, pim_ff, pre_in, pim_in;
   logic nre_ff, nim_ff, nre_in, nim_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   logic signed [31:0] x_i, y_i;
   logic signed [N_W-1:0] dn;
   logic [63:0] t_s, t_r, t_b;
   logic [64:0] t_num;
   logic [32:0] t_q;
   logic [31:0] t_cm, t_uw, t_zm;
   logic [N_W-1:0] t_cnt;
   logic signed [31:0] t_bi, t_t;
   logic signed [39:0] t_h;
   logic [39:0] t_hm;
   logic [4:0] t_k;
   logic [47:0] d_out [4];

   assign adv = !v_ff[NS-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   always_comb begin
      x_i = req_tdata[31:0];
      y_i = req_tdata[63:32];
      dn = N_W'(degree_ff);
      if (dn > $signed(N_W'(MAX_DEGREE))) dn = N_W'(MAX_DEGREE);
      if (dn < -$signed(N_W'(MAX_DEGREE))) dn = -$signed(N_W'(MAX_DEGREE));

      v_in[0] = req_tvalid;
      for (int i = 1; i < NS; i++) begin
         v_in[i] = v_ff[i-1];
         side_in[i] = side_ff[i-1];
      end
      side_in[0].zero = (x_i == 32'sd0) && (y_i == 32'sd0);
      side_in[0].hw = req_tuser[0];
      side_in[0].wd = req_tuser[1];
      side_in[0].w = req_tuser[0] ? $signed(req_tdata[95:64]) : 32'sh0001_0000;
      side_in[0].n = dn;
      side_in[0].negx = x_i[31];
      side_in[0].negy = y_i[31];
      side_in[0].k = 5'd0;
      ax0_in = x_i[31] ? (~x_i + 32'd1) : x_i;
      ay0_in = y_i[31] ? (~y_i + 32'd1) : y_i;

      // scale so the larger magnitude reaches 2^30
      side_in[1].k = lz_shift((ax0_ff > ay0_ff) ? ax0_ff : ay0_ff);
      a2_in = ax1_ff << side_ff[1].k;
      b2_in = ay1_ff << side_ff[1].k;
      aa3_in = 64'(a2_ff) * 64'(a2_ff);
      bb3_in = 64'(b2_ff) * 64'(b2_ff);
      ss4_in = aa3_ff + bb3_ff;

      // square root, one result bit per stage
      for (int q = 0; q < NSQ; q++) begin
         t_s = (q == 0) ? ss4_ff : sq_s_ff[q-1];
         t_r = (q == 0) ? 64'd0 : sq_r_ff[q-1];
         t_b = 64'd1 << (62 - 2*q);
         if (t_s >= t_r + t_b) begin
            sq_s_in[q] = t_s - (t_r + t_b);
            sq_r_in[q] = (t_r >> 1) + t_b;
         end else begin
            sq_s_in[q] = t_s;
            sq_r_in[q] = t_r >> 1;
         end
         sq_a_in[q] = (q == 0) ? a4_ff : sq_a_ff[q-1];
         sq_b_in[q] = (q == 0) ? b4_ff : sq_b_ff[q-1];
      end

      // unit vector dividers
      t_num = (65'(sq_a_ff[NSQ-1]) << 30) + 65'(sq_r_ff[NSQ-1][31:1]);
      cdx_in[0] = div_step(div_type'({t_num[64:33], t_num[32:0]}), sq_r_ff[NSQ-1][31:0]);
      t_num = (65'(sq_b_ff[NSQ-1]) << 30) + 65'(sq_r_ff[NSQ-1][31:1]);
      cdy_in[0] = div_step(div_type'({t_num[64:33], t_num[32:0]}), sq_r_ff[NSQ-1][31:0]);
      cd_d_in[0] = sq_r_ff[NSQ-1][31:0];
      for (int c = 1; c < NDV; c++) begin
         cdx_in[c] = div_step(cdx_ff[c-1], cd_d_ff[c-1]);
         cdy_in[c] = div_step(cdy_ff[c-1], cd_d_ff[c-1]);
         cd_d_in[c] = cd_d_ff[c-1];
      end

      t_q = cdx_ff[NDV-1].nq;
      t_cm = (t_q > 33'h4000_0000) ? 32'h4000_0000 : t_q[31:0];
      car_in[0].cx = side_ff[CL-1].negx ? $signed(32'd0 - t_cm) : $signed(t_cm);
      t_q = cdy_ff[NDV-1].nq;
      t_cm = (t_q > 33'h4000_0000) ? 32'h4000_0000 : t_q[31:0];
      car_in[0].cy = side_ff[CL-1].negy ? $signed(32'd0 - t_cm) : $signed(t_cm);
      car_in[0].r = cd_d_ff[NDV-1];
      car_in[0].zr = ONE30;
      car_in[0].zi = 32'sd0;

      for (int c = 1; c < NC; c++) begin
         car_in[c] = car_ff[c-1];
      end

      // power: one complex multiply per degree step
      for (int p = 1; p <= MAX_DEGREE; p++) begin
         t_cnt = side_ff[CL+p-1].n[N_W-1] ? N_W'(-side_ff[CL+p-1].n) : side_ff[CL+p-1].n;
         t_bi = side_ff[CL+p-1].n[N_W-1] ? -car_ff[p-1].cy : car_ff[p-1].cy;
         if (N_W'(p) <= t_cnt) begin
            car_in[p].zr = clamp1(rnd30(64'(car_ff[p-1].zr) * 64'(car_ff[p-1].cx)
                                      - 64'(car_ff[p-1].zi) * 64'(t_bi)));
            car_in[p].zi = clamp1(rnd30(64'(car_ff[p-1].zr) * 64'(t_bi)
                                      + 64'(car_ff[p-1].zi) * 64'(car_ff[p-1].cx)));
         end
      end

      // gradient: order dre_dx, dre_dy, dim_dx, dim_dy
      tp_in[0] = 64'(car_ff[C_T-1].cy) * 64'(car_ff[C_T-1].zi);
      tp_in[1] = 64'(car_ff[C_T-1].cx) * 64'(car_ff[C_T-1].zi);
      tp_in[2] = 64'(car_ff[C_T-1].cy) * 64'(car_ff[C_T-1].zr);
      tp_in[3] = 64'(car_ff[C_T-1].cx) * 64'(car_ff[C_T-1].zr);

      for (int i = 0; i < 4; i++) begin
         t_t = 32'(rnd30(tp_ff[i]));
         t_h = 40'(t_t) * 40'(side_ff[CL+C_T].n);
         hh_in[i] = (i == 1 || i == 2) ? -t_h : t_h;

         t_hm = hh_ff[i][39] ? 40'(-hh_ff[i]) : hh_ff[i];
         t_k = (side_ff[CL+C_H].k > 5'd16) ? 5'd16 : side_ff[CL+C_H].k;
         t_num = (65'(t_hm) << (5'd10 + t_k)) + 65'(car_ff[C_H].r[31:1]);
         nm_in[i] = div_type'({t_num[64:33], t_num[32:0]});
         nneg_in[i] = hh_ff[i][39];

         pd_in[0][i] = div_step(nm_ff[i], car_ff[C_NM].r);
         pneg_in[0][i] = nneg_ff[i];
         for (int d = 1; d < NDV; d++) begin
            pd_in[d][i] = div_step(pd_ff[d-1][i], car_ff[C_PD+d-1].r);
            pneg_in[d][i] = pneg_ff[d-1][i];
         end

         t_k = (side_ff[CL+C_G-1].k > 5'd16) ? side_ff[CL+C_G-1].k - 5'd16 : 5'd0;
         g_in[i] = 48'(pd_ff[NDV-1][i].nq) << t_k;
         gneg_in[i] = pneg_ff[NDV-1][i];
      end

      t_uw = side_ff[CL+C_G].w[31] ? 32'(-side_ff[CL+C_G].w) : side_ff[CL+C_G].w;
      for (int i = 0; i < 4; i++) begin
         plo_in[i] = 64'(g_ff[i][31:0]) * 64'(t_uw);
         phi_in[i] = 48'(g_ff[i][47:32]) * 48'(t_uw);
         pn_in[i] = (gneg_ff[i] && g_ff[i] != 48'd0) != side_ff[CL+C_G].w[31];
      end
      t_zm = car_ff[C_G].zr[31] ? 32'(-car_ff[C_G].zr) : car_ff[C_G].zr;
      pre_in = 64'(t_zm) * 64'(t_uw);
      nre_in = car_ff[C_G].zr[31] != side_ff[CL+C_G].w[31];
      t_zm = car_ff[C_G].zi[31] ? 32'(-car_ff[C_G].zi) : car_ff[C_G].zi;
      pim_in = 64'(t_zm) * 64'(t_uw);
      nim_in = car_ff[C_G].zi[31] != side_ff[CL+C_G].w[31];

      for (int i = 0; i < 4; i++) begin
         d_out[i] = side_ff[CL+C_M].wd ? sat48(plo_ff[i], phi_ff[i], pn_ff[i]) : 48'd0;
      end
      rsp_data_in = {
         (side_ff[CL+C_M].wd && side_ff[CL+C_M].hw) ? car_ff[C_M].zi : 32'sd0,
         (side_ff[CL+C_M].wd && side_ff[CL+C_M].hw) ? car_ff[C_M].zr : 32'sd0,
         d_out[3], d_out[2], d_out[1], d_out[0],
         sat32(pim_ff, nim_ff), sat32(pre_ff, nre_ff)
      };
      if (side_ff[CL+C_M].zero) rsp_data_in = '0;
      rsp_user_in = side_ff[CL+C_M].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 6'sd0;
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
      end else begin
         if (csr_wen) degree_ff <= csr_wdata;
         if (adv) v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
         ax0_ff <= ax0_in;
         ay0_ff <= ay0_in;
         ax1_ff <= ax0_ff;
         ay1_ff <= ay0_ff;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         aa3_ff <= aa3_in;
         bb3_ff <= bb3_in;
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         ss4_ff <= ss4_in;
         a4_ff <= a3_ff;
         b4_ff <= b3_ff;
         sq_s_ff <= sq_s_in;
         sq_r_ff <= sq_r_in;
         sq_a_ff <= sq_a_in;
         sq_b_ff <= sq_b_in;
         cdx_ff <= cdx_in;
         cdy_ff <= cdy_in;
         cd_d_ff <= cd_d_in;
         car_ff <= car_in;
         tp_ff <= tp_in;
         hh_ff <= hh_in;
         nm_ff <= nm_in;
         nneg_ff <= nneg_in;
         pd_ff <= pd_in;
         pneg_ff <= pneg_in;
         g_ff <= g_in;
         gneg_ff <= gneg_in;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         pn_ff <= pn_in;
         pre_ff <= pre_in;
         pim_ff <= pim_in;
         nre_ff <= nre_in;
         nim_ff <= nim_in;
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/chwg_check.sv -----
`default_nettype none
`include "assert_macros.svh"
module chwg_check
   import chwg_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic [0:0]       rsp_tuser
);

   logic stalled;
   logic zero_rsp;
   logic signed [31:0] dre_dw;
   logic signed [31:0] dim_dw;

   assign stalled = rsp_tvalid && !rsp_tready;
   assign zero_rsp = rsp_tvalid && rsp_tuser[0];
   assign dre_dw = rsp_tdata[DRE_DW_LSB+31:DRE_DW_LSB];
   assign dim_dw = rsp_tdata[DIM_DW_LSB+31:DIM_DW_LSB];

   `CHWG_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "valid after reset")
   `CHWG_ASSERT(a_hold, clock, reset, stalled |=> rsp_tvalid && $stable(rsp_tdata), "data moved")
   `CHWG_ASSERT(a_ready, clock, reset, !rsp_tvalid |-> req_tready, "input blocked")
   `CHWG_ASSERT(a_zero, clock, reset, zero_rsp |-> rsp_tdata == '0, "zero length not cleared")
   `CHWG_ASSERT(a_dw, clock, reset, rsp_tvalid |-> dre_dw <= ONE30 && dim_dw >= -ONE30, "dw range")

endmodule

bind cylindrical_harmonic_with_gradient chwg_check u_chwg_check (.*);
`default_nettype wire

// ----- tb/sv/cylindrical_harmonic_with_gradient_checker.sv -----
`timescale 1ns / 100ps
module cylindrical_harmonic_with_gradient_checker
   import chwg_pkg::*;
#(
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wen,
   input  wire logic [5:0]       csr_wdata,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,
   input  wire logic [0:0]       rsp_tuser,
   output int                    fail_count
);

   localparam longint LIM32 = 64'sd2147483647;
   localparam longint LIM48 = (64'sd1 <<< 47) - 1;
   localparam longint UNIT = 64'sd1 <<< 30;

   logic [5:0] degree_q;
   logic [RSP_W:0] harmonic_q[$];
   int mismatches;
   int pending;

   assign fail_count = mismatches + pending;

   function automatic longint round_shift(longint v, int sh);
      longint unsigned mg;
      mg = v < 0 ? -v : v;
      mg = (mg + (64'd1 << (sh - 1))) >> sh;
      return v < 0 ? -longint'(mg) : longint'(mg);
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > UNIT) return UNIT;
      if (v < -UNIT) return -UNIT;
      return v;
   endfunction

   function automatic longint scale_sat(longint a, longint w, int sh, longint lim);
      logic signed [127:0] p;
      logic signed [127:0] mg;
      p = a;
      p = p * w;
      mg = p < 0 ? -p : p;
      mg = (mg + (128'sd1 <<< (sh - 1))) >>> sh;
      if (p < 0) return (mg > lim + 1) ? -lim - 1 : -longint'(mg);
      return (mg > lim) ? lim : longint'(mg);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint gradient(longint c, longint zc, longint n, bit negate,
                                       int k, longint unsigned rn, longint w);
      longint h;
      longint unsigned hm, g;
      longint gs;
      h = round_shift(c * zc, 30) * n;
      if (negate) h = -h;
      hm = h < 0 ? -h : h;
      if (k <= 16) g = ((hm << (10 + k)) + rn / 2) / rn;
      else g = (((hm << 26) + rn / 2) / rn) << (k - 16);
      gs = h < 0 ? -longint'(g) : longint'(g);
      return scale_sat(gs, w, 16, LIM48);
   endfunction

   function automatic logic [RSP_W:0] harmonic(logic [REQ_W-1:0] d, logic [1:0] u,
                                               logic [5:0] deg);
      logic [RSP_W:0] o;
      longint x, y, w, n, cx, cy, zr, zi, nr, ni, bi;
      longint unsigned ax, ay, m, rn;
      int k, cnt;
      o = '0;
      x = longint'($signed(d[31:0]));
      y = longint'($signed(d[63:32]));
      w = u[0] ? longint'($signed(d[95:64])) : 64'sd65536;
      n = longint'($signed(deg));
      if (x == 0 && y == 0) begin
         o[RSP_W] = 1'b1;
         return o;
      end
      if (n > MAX_DEGREE) n = MAX_DEGREE;
      if (n < -MAX_DEGREE) n = -MAX_DEGREE;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      m = ax > ay ? ax : ay;
      k = 0;
      while (m < (64'd1 << 30)) begin
         m = m << 1;
         ax = ax << 1;
         ay = ay << 1;
         k++;
      end
      rn = int_sqrt(ax * ax + ay * ay);
      cx = clamp_unit(longint'(((ax << 30) + rn / 2) / rn));
      cy = clamp_unit(longint'(((ay << 30) + rn / 2) / rn));
      if (x < 0) cx = -cx;
      if (y < 0) cy = -cy;
      bi = n < 0 ? -cy : cy;
      zr = UNIT;
      zi = 0;
      cnt = int'(n < 0 ? -n : n);
      for (int i = 0; i < cnt; i++) begin
         nr = clamp_unit(round_shift(zr * cx - zi * bi, 30));
         ni = clamp_unit(round_shift(zr * bi + zi * cx, 30));
         zr = nr;
         zi = ni;
      end
      o[31:0] = 32'(scale_sat(zr, w, 30, LIM32));
      o[63:32] = 32'(scale_sat(zi, w, 30, LIM32));
      if (u[1]) begin
         o[111:64] = 48'(gradient(cy, zi, n, 1'b0, k, rn, w));
         o[159:112] = 48'(gradient(cx, zi, n, 1'b1, k, rn, w));
         o[207:160] = 48'(gradient(cy, zr, n, 1'b1, k, rn, w));
         o[255:208] = 48'(gradient(cx, zr, n, 1'b0, k, rn, w));
         if (u[0]) begin
            o[287:256] = 32'(zr);
            o[319:288] = 32'(zi);
         end
      end
      return o;
   endfunction

   function automatic int field_lsb(int i);
      case (i)
         0: return 0;
         1: return 32;
         2: return 64;
         3: return 112;
         4: return 160;
         5: return 208;
         6: return 256;
         7: return 288;
         default: return RSP_W;
      endcase
   endfunction

   function automatic string field_name(int i);
      case (i)
         0: return "harm_re";
         1: return "imag_part";
         2: return "dre_dx";
         3: return "dre_dy";
         4: return "dim_dx";
         5: return "dim_dy";
         6: return "dre_dw";
         7: return "dim_dw";
         default: return "zero_length";
      endcase
   endfunction

   always @(posedge clock) begin
      logic [RSP_W:0] want, got, fmask;
      int lo, wd;
      if (reset) begin
         degree_q <= '0;
         harmonic_q.delete();
         pending <= 0;
         mismatches <= 0;
      end else begin
         if (csr_wen) degree_q <= csr_wdata;
         if (req_tvalid && req_tready) harmonic_q.push_back(harmonic(req_tdata, req_tuser,
                                                                     degree_q));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (harmonic_q.size() == 0) begin
               if (mismatches < 10) $display("unexpected transfer on rsp: %h", got);
               mismatches <= mismatches + 1;
            end else begin
               want = harmonic_q.pop_front();
               for (int i = 0; i < 9; i++) begin
                  lo = field_lsb(i);
                  wd = field_lsb(i + 1) - lo;
                  if (i == 8) wd = 1;
                  fmask = ((RSP_W+1)'(1) << wd) - 1;
                  fmask = fmask << lo;
                  if ((want & fmask) != (got & fmask)) begin
                     if (mismatches < 10)
                        $display("%s: expected %h actual %h", field_name(i),
                                 (want & fmask) >> lo, (got & fmask) >> lo);
                     mismatches <= mismatches + 1;
                     break;
                  end
               end
            end
         end
         pending <= harmonic_q.size();
      end
   end

endmodule

// ----- tb/sv/cylindrical_harmonic_with_gradient_test.sv -----
`timescale 1ns / 100ps
module cylindrical_harmonic_with_gradient_test;
   import chwg_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen = 1'b0;
   logic [5:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   int fail_count;

   int send_idle;
   int recv_idle;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;
   int sent = 0;
   int received = 0;

   logic signed [5:0] degrees[11] = '{6'sd0, 6'sd3, 6'sd16, -6'sd16, 6'sd31, -6'sd32, 6'sd1,
                                      -6'sd1, 6'sd7, -6'sd5, 6'sd12};

   cylindrical_harmonic_with_gradient u_dut (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   cylindrical_harmonic_with_gradient_checker u_checker (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .fail_count(fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver, with long hold-off on request
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) received <= received + 1;
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return $urandom;
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   task automatic transfer(logic [31:0] x, logic [31:0] y, logic [31:0] w,
                           logic hw, logic wd, bit gaps);
      if (gaps && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata <= {w, y, x};
      req_tuser <= {wd, hw};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (received != sent) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic random_items(int count, bit gaps);
      logic [31:0] x, y, w;
      for (int i = 0; i < count; i++) begin
         x = rand_coord();
         y = rand_coord();
         w = $urandom_range(3) == 0 ? $urandom : $signed($urandom) >>> $urandom_range(8, 31);
         transfer(x, y, w, $urandom_range(1), $urandom_range(3) != 0, gaps);
      end
   endtask

   initial begin
      send_idle = 35;
      recv_idle = 82;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 11; p++) begin
         if (p == 4) begin
            send_idle = 82;
            recv_idle = 35;
         end else if (p == 8) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (p != 0) begin
            drain();
            csr_wen <= 1'b1;
            csr_wdata <= degrees[p];
            @(posedge clock);
            csr_wen <= 1'b0;
         end
         if (p == 1) begin
            transfer(32'd0, 32'd0, 32'h0001_0000, 1, 1, 1);
            transfer(32'd0, 32'd0, 32'h7fff_ffff, 0, 0, 1);
            transfer(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1);
            transfer(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1);
            transfer(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1, 1, 1);
            transfer(32'd1, 32'd0, 32'h7fff_ffff, 1, 1, 1);
            transfer(32'd0, 32'd1, 32'h8000_0000, 1, 1, 1);
            transfer(32'hffff_ffff, 32'd1, 32'h0001_0000, 0, 1, 1);
            transfer(32'd1, 32'hffff_ffff, 32'h0001_0000, 1, 0, 1);
            transfer(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1, 1, 1);
            transfer(32'hffff_0000, 32'd0, 32'h0000_8000, 1, 1, 1);
            transfer(32'd0, 32'hffff_0000, 32'hffff_8000, 1, 1, 1);
            transfer(32'h4000_0000, 32'd3, 32'd0, 1, 1, 1);
            transfer(32'd3, 32'h3fff_ffff, 32'd1, 1, 1, 1);
            transfer(32'h1234_5678, 32'hedcb_a988, 32'h5555_5555, 0, 1, 1);
            transfer(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1, 1, 1);
            transfer(32'd1, 32'd1, 32'h7fff_ffff, 1, 1, 1);
            transfer(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 1, 1, 1);
            random_items(37, 1);
         end else if (p == 2) begin
            hold_req <= hold_req + 1;
            random_items(200, 0);
         end else if (p == 5) begin
            random_items(27, 1);
            drain();
            random_items(28, 1);
         end else begin
            random_items(55, 1);
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (received != sent) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/chwg_pkg.sv
rtl/core/cylindrical_harmonic_with_gradient.sv
rtl/core/chwg_check.sv
tb/sv/cylindrical_harmonic_with_gradient_checker.sv
tb/sv/cylindrical_harmonic_with_gradient_test.sv
